/* sv/mcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command scheduler package
// Shared types, register indexes and codes for the scheduler blocks.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_RPM_MIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RPM_MAX      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHANGE_THR   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESEND_MS    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BROADCAST    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SLAVE_ADDR   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_DIR   = 3'd6;

  // Opcodes of an input beat.
  localparam logic OP_SET_SPEED = 1'b0;
  localparam logic OP_SERVICE   = 1'b1;

  // Write kinds.
  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_CMD   = 1'b1;

  // Scheduler phase codes.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SPEED = 2'd1;
  localparam logic [1:0] PH_CMD   = 2'd2;

  // Direction codes.
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;
  localparam logic [1:0] DIR_NONE = 2'd3;

  localparam logic [15:0] WORD_ZERO = 16'h0000;
  localparam logic [15:0] WORD_ONES = 16'hFFFF;

  typedef struct packed {
    logic [15:0] rpm_min;
    logic [15:0] rpm_max;
    logic [15:0] change_threshold;
    logic [31:0] resend_interval_ms;
    logic        broadcast_writes;
    logic [7:0]  slave_address;
    logic        invert_direction;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] rpm_request;
    logic [31:0]        now_ms;
    logic               bus_busy;
    logic               bus_accepts;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic        write_kind;
    logic [7:0]  target_address;
    logic [15:0] word_high;
    logic [15:0] word_low;
  } out_item_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [1:0]  direction;
  } speed_req_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] sent_direction;
  } sched_status_t;

endpackage

/* sv/mcs_shaper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed request shaper
// Turns a signed rpm request into a clamped magnitude and a direction code.
// ----------------------------------------------------------------------------
module mcs_shaper import mcs_pkg::*; (
  input  logic signed [31:0] rpm_request,
  input  cfg_t               cfg,
  output speed_req_t         req
);

  logic signed [32:0] req_ext;
  logic signed [32:0] signed_req;
  logic [31:0]        mag;
  logic [31:0]        mag_min;
  logic [31:0]        mag_sat;

  always_comb begin
    req_ext    = {rpm_request[31], rpm_request};
    // The negation is done one bit wider so that the most negative request
    // yields a magnitude of two to the thirty-first.
    signed_req = cfg.invert_direction ? -req_ext : req_ext;
    mag        = signed_req[32] ? 32'(-signed_req) : signed_req[31:0];

    if ((mag != 32'd0) && (mag < {16'd0, cfg.rpm_min})) begin
      mag_min = 32'd0;
    end else begin
      mag_min = mag;
    end

    if (mag_min > {16'd0, cfg.rpm_max}) begin
      mag_sat = {16'd0, cfg.rpm_max};
    end else begin
      mag_sat = mag_min;
    end

    req.speed = mag_sat[15:0];
    if (mag_sat == 32'd0) begin
      req.direction = DIR_STOP;
    end else if (!signed_req[32]) begin
      req.direction = DIR_FWD;
    end else begin
      req.direction = DIR_REV;
    end
  end

endmodule

/* sv/mcs_sched.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Write scheduler
// Holds the pending and sent speed and direction, and decides on each
// service beat whether a speed or a command write goes out.
// ----------------------------------------------------------------------------
module mcs_sched import mcs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  in_item_t      item,
  input  speed_req_t    req,
  input  cfg_t          cfg,
  output out_item_t     result,
  output sched_status_t status
);

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] pending_speed_r, pending_speed_nxt;
  logic [15:0] sent_speed_r, sent_speed_nxt;
  logic [1:0]  pending_dir_r, pending_dir_nxt;
  logic [1:0]  sent_dir_r, sent_dir_nxt;
  logic [31:0] last_cmd_time_r, last_cmd_time_nxt;

  logic [15:0] diff;
  logic [31:0] age;
  logic        speed_changed;
  logic        cmd_changed;
  logic        stale;
  logic [1:0]  ph;
  logic [7:0]  dest_addr;

  always_comb begin
    phase_nxt         = phase_r;
    pending_speed_nxt = pending_speed_r;
    sent_speed_nxt    = sent_speed_r;
    pending_dir_nxt   = pending_dir_r;
    sent_dir_nxt      = sent_dir_r;
    last_cmd_time_nxt = last_cmd_time_r;
    result            = '0;

    diff = (pending_speed_r > sent_speed_r) ? (pending_speed_r - sent_speed_r)
                                            : (sent_speed_r - pending_speed_r);
    age           = item.now_ms - last_cmd_time_r;
    speed_changed = diff > cfg.change_threshold;
    cmd_changed   = pending_dir_r != sent_dir_r;
    stale         = age > cfg.resend_interval_ms;
    dest_addr     = cfg.broadcast_writes ? 8'd0 : cfg.slave_address;
    ph            = phase_r;

    if (item.opcode == OP_SET_SPEED) begin
      pending_speed_nxt = req.speed;
      pending_dir_nxt   = req.direction;
    end else if (!item.bus_busy) begin
      // A phase left over from a refused write is kept; otherwise choose anew.
      if ((phase_r != PH_SPEED) && (phase_r != PH_CMD)) begin
        if (speed_changed) begin
          ph = PH_SPEED;
        end else if (cmd_changed || stale) begin
          ph = PH_CMD;
        end else begin
          ph = PH_IDLE;
        end
      end
      phase_nxt = ph;

      if (item.bus_accepts && (ph != PH_IDLE)) begin
        result.write_valid    = 1'b1;
        result.target_address = dest_addr;
        result.word_high      = WORD_ZERO;
        if (ph == PH_SPEED) begin
          result.write_kind = KIND_SPEED;
          result.word_low   = pending_speed_r & WORD_ONES;
          sent_speed_nxt    = pending_speed_r;
          phase_nxt         = cmd_changed ? PH_CMD : PH_IDLE;
        end else begin
          result.write_kind = KIND_CMD;
          result.word_low   = {14'd0, pending_dir_r};
          sent_dir_nxt      = pending_dir_r;
          last_cmd_time_nxt = item.now_ms;
          phase_nxt         = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      pending_speed_r <= 16'd0;
      sent_speed_r    <= 16'd0;
      pending_dir_r   <= DIR_STOP;
      sent_dir_r      <= DIR_NONE;
      last_cmd_time_r <= 32'd0;
    end else if (adv) begin
      phase_r         <= phase_nxt;
      pending_speed_r <= pending_speed_nxt;
      sent_speed_r    <= sent_speed_nxt;
      pending_dir_r   <= pending_dir_nxt;
      sent_dir_r      <= sent_dir_nxt;
      last_cmd_time_r <= last_cmd_time_nxt;
    end
  end

  assign status.phase          = phase_r;
  assign status.sent_direction = sent_dir_r;

endmodule

/* sv/motor_command_scheduler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command scheduler core
// Turns speed requests and service beats into register writes for one motor
// driver on a shared bus.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle unless out_ready stalls it, and
// returns exactly one result beat for each: a beat waits in the input register,
// where the shaper and the scheduler decide on the write in a single pass, and
// then in the result register. The result register lets a new beat enter while
// an earlier result still waits on out_ready. Configuration registers are
// written through cfg_we, cfg_idx and cfg_wdata and should only change while
// no beat is in flight.
module motor_command_scheduler_core import mcs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t          cfg_r;
  logic          in_vld_r;
  in_item_t      in_item_r;
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          adv;
  speed_req_t    req;
  out_item_t     result;
  sched_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rpm_min            <= 16'd80;
      cfg_r.rpm_max            <= 16'd3000;
      cfg_r.change_threshold   <= 16'd5;
      cfg_r.resend_interval_ms <= 32'd200;
      cfg_r.broadcast_writes   <= 1'b0;
      cfg_r.slave_address      <= 8'd1;
      cfg_r.invert_direction   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RPM_MIN:    cfg_r.rpm_min            <= cfg_wdata[15:0];
        CFG_RPM_MAX:    cfg_r.rpm_max            <= cfg_wdata[15:0];
        CFG_CHANGE_THR: cfg_r.change_threshold   <= cfg_wdata[15:0];
        CFG_RESEND_MS:  cfg_r.resend_interval_ms <= cfg_wdata;
        CFG_BROADCAST:  cfg_r.broadcast_writes   <= cfg_wdata[0];
        CFG_SLAVE_ADDR: cfg_r.slave_address      <= cfg_wdata[7:0];
        CFG_INVERT_DIR: cfg_r.invert_direction   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or
  // being emptied in the same cycle.
  assign adv      = in_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  mcs_shaper u_shaper (
    .rpm_request (in_item_r.rpm_request),
    .cfg         (cfg_r),
    .req         (req)
  );

  mcs_sched u_sched (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (in_item_r),
    .req    (req),
    .cfg    (cfg_r),
    .result (result),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A beat that carries no write is all zero.
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_valid |-> out_data == '0)
    else $error("empty result beat carries nonzero fields");

  // A speed write never has a nonzero upper word.
  a_speed_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_valid && (out_data.write_kind == KIND_SPEED)
    |-> out_data.word_high == WORD_ZERO)
    else $error("speed write with nonzero upper word");

  // Once a command has gone out, a direction has been recorded as sent.
  a_cmd_records_dir: assert property (@(posedge clk) disable iff (!rst_n)
    adv && result.write_valid && (result.write_kind == KIND_CMD)
    |=> status.sent_direction != DIR_NONE)
    else $error("command write did not record the sent direction");

  // A completed write never leaves the speed phase selected.
  a_write_leaves_phase: assert property (@(posedge clk) disable iff (!rst_n)
    adv && result.write_valid |=> status.phase != PH_SPEED)
    else $error("phase still on speed after a completed write");

endmodule

/* verif/mcs_write_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command scheduler write checker
// Watches the input, result and configuration ports of the scheduler core,
// predicts the bus write that each input beat must produce and compares every
// result beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mcs_write_checker import mcs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  writes_due,
  output int                  speed_writes,
  output int                  command_writes
);

  cfg_t        settings;
  logic [1:0]  sched_phase;
  logic [15:0] pend_speed;
  logic [15:0] sent_speed;
  logic [1:0]  pend_dir;
  logic [1:0]  sent_dir;
  logic [31:0] last_cmd_ms;
  out_item_t   expected_writes[$];

  function automatic void apply_speed_request(input logic signed [31:0] req);
    longint r;
    longint m;
    r = longint'(req);
    if (settings.invert_direction) r = -r;
    m = (r < 0) ? -r : r;
    if (m > 0 && m < longint'(settings.rpm_min)) m = 0;
    if (m > longint'(settings.rpm_max)) m = longint'(settings.rpm_max);
    pend_speed = 16'(m);
    if (m == 0) pend_dir = DIR_STOP;
    else if (r > 0) pend_dir = DIR_FWD;
    else pend_dir = DIR_REV;
  endfunction

  function automatic out_item_t schedule_write(input in_item_t beat);
    out_item_t   w;
    logic [15:0] gap;
    logic [31:0] age;
    w = '0;
    if (beat.opcode == OP_SET_SPEED) begin
      apply_speed_request(beat.rpm_request);
      return w;
    end
    if (beat.bus_busy) return w;
    // A phase left pending by a refused write is kept; anything else re-decides.
    if (sched_phase != PH_SPEED && sched_phase != PH_CMD) begin
      gap = (pend_speed > sent_speed) ? pend_speed - sent_speed : sent_speed - pend_speed;
      age = beat.now_ms - last_cmd_ms;
      if (gap > settings.change_threshold) sched_phase = PH_SPEED;
      else if (pend_dir != sent_dir || age > settings.resend_interval_ms) sched_phase = PH_CMD;
      else begin
        sched_phase = PH_IDLE;
        return w;
      end
    end
    if (!beat.bus_accepts) return w;
    w.write_valid    = 1'b1;
    w.target_address = settings.broadcast_writes ? 8'h00 : settings.slave_address;
    w.word_high      = WORD_ZERO;
    if (sched_phase == PH_SPEED) begin
      w.write_kind = KIND_SPEED;
      w.word_low   = pend_speed;
      sent_speed   = pend_speed;
      sched_phase  = (pend_dir != sent_dir) ? PH_CMD : PH_IDLE;
    end else begin
      w.write_kind = KIND_CMD;
      w.word_low   = {14'd0, pend_dir};
      sent_dir     = pend_dir;
      last_cmd_ms  = beat.now_ms;
      sched_phase  = PH_IDLE;
    end
    return w;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    out_item_t oldest;
    if (!rst_n) begin
      settings    <= '{rpm_min: 16'd80, rpm_max: 16'd3000, change_threshold: 16'd5,
                       resend_interval_ms: 32'd200, broadcast_writes: 1'b0,
                       slave_address: 8'd1, invert_direction: 1'b0};
      sched_phase  = PH_IDLE;
      pend_speed   = '0;
      sent_speed   = '0;
      pend_dir     = DIR_STOP;
      sent_dir     = DIR_NONE;
      last_cmd_ms  = '0;
      expected_writes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          mismatches++;
          $error("result beat arrived with no prediction outstanding");
        end else begin
          oldest = expected_writes.pop_front();
          check_field("write_valid", 32'(oldest.write_valid), 32'(out_data.write_valid));
          check_field("write_kind", 32'(oldest.write_kind), 32'(out_data.write_kind));
          check_field("target_address", 32'(oldest.target_address),
                      32'(out_data.target_address));
          check_field("word_high", 32'(oldest.word_high), 32'(out_data.word_high));
          check_field("word_low", 32'(oldest.word_low), 32'(out_data.word_low));
          if (oldest.write_valid && oldest.write_kind == KIND_SPEED) speed_writes++;
          if (oldest.write_valid && oldest.write_kind == KIND_CMD) command_writes++;
        end
      end
      if (in_valid && in_ready) expected_writes.push_back(schedule_write(in_data));
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RPM_MIN:    settings.rpm_min            <= cfg_wdata[15:0];
          CFG_RPM_MAX:    settings.rpm_max            <= cfg_wdata[15:0];
          CFG_CHANGE_THR: settings.change_threshold   <= cfg_wdata[15:0];
          CFG_RESEND_MS:  settings.resend_interval_ms <= cfg_wdata;
          CFG_BROADCAST:  settings.broadcast_writes   <= cfg_wdata[0];
          CFG_SLAVE_ADDR: settings.slave_address      <= cfg_wdata[7:0];
          CFG_INVERT_DIR: settings.invert_direction   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    writes_due = expected_writes.size();
  end

endmodule

/* verif/tb_motor_command_scheduler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command scheduler core testbench
// Drives a directed sequence and then randomised speed requests and service
// beats through several register settings and handshake pacing modes; the
// write checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_motor_command_scheduler_core;
  import mcs_pkg::*;

  localparam int QUIET_LIMIT       = 1000;
  localparam int SETTLE_CYCLES     = 4;
  localparam int BEATS_PER_SETTING = 93;
  localparam int SETTING_COUNT     = 7;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  int          mismatch_total;
  int          results_due;
  int          speed_writes;
  int          command_writes;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          quiet_cycles = 0;
  int          beats_sent = 0;
  int          settings_loaded = 0;
  logic [31:0] clock_ms;
  logic [31:0] last_rpm;
  cfg_t        active;

  motor_command_scheduler_core dut (.*);

  mcs_write_checker write_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatch_total),
    .writes_due     (results_due),
    .speed_writes   (speed_writes),
    .command_writes (command_writes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t speed_beat(input logic [31:0] rpm);
    in_item_t b;
    b.opcode      = OP_SET_SPEED;
    b.rpm_request = rpm;
    b.now_ms      = $urandom;
    b.bus_busy    = 1'($urandom_range(1));
    b.bus_accepts = 1'($urandom_range(1));
    return b;
  endfunction

  function automatic in_item_t tick_beat(input logic [31:0] now, input logic busy,
                                         input logic accepts);
    in_item_t b;
    b.opcode      = OP_SERVICE;
    b.rpm_request = $urandom;
    b.now_ms      = now;
    b.bus_busy    = busy;
    b.bus_accepts = accepts;
    return b;
  endfunction

  function automatic cfg_t phase_settings(input int p);
    cfg_t s;
    case (p)
      0: s = '{rpm_min: 16'd80, rpm_max: 16'd3000, change_threshold: 16'd5,
               resend_interval_ms: 32'd200, broadcast_writes: 1'b0,
               slave_address: 8'd1, invert_direction: 1'b0};
      1: s = '{rpm_min: 16'd0, rpm_max: 16'hFFFF, change_threshold: 16'd0,
               resend_interval_ms: 32'd0, broadcast_writes: 1'b1,
               slave_address: 8'd247, invert_direction: 1'b1};
      2: s = '{rpm_min: 16'hFFFF, rpm_max: 16'hFFFF, change_threshold: 16'hFFFF,
               resend_interval_ms: 32'hFFFF_FFFF, broadcast_writes: 1'b0,
               slave_address: 8'hFF, invert_direction: 1'b0};
      4: s = '{rpm_min: 16'd1000, rpm_max: 16'd200, change_threshold: 16'd1,
               resend_interval_ms: 32'd1, broadcast_writes: 1'b0,
               slave_address: 8'd0, invert_direction: 1'b1};
      6: s = '{rpm_min: 16'd0, rpm_max: 16'd0, change_threshold: 16'd0,
               resend_interval_ms: 32'h8000_0000, broadcast_writes: 1'b1,
               slave_address: 8'd0, invert_direction: 1'b0};
      default: begin
        s.rpm_min            = 16'($urandom_range(300));
        s.rpm_max            = 16'($urandom_range(6000, 50));
        s.change_threshold   = 16'($urandom_range(60));
        s.resend_interval_ms = 32'($urandom_range(600));
        s.broadcast_writes   = 1'($urandom_range(1));
        s.slave_address      = 8'($urandom_range(247, 1));
        s.invert_direction   = 1'($urandom_range(1));
      end
    endcase
    return s;
  endfunction

  // Requests, mostly near the interesting boundaries, or more often ticks whose
  // time steps are small, straddle the keep-alive interval or are random.
  function automatic in_item_t random_beat();
    int          pick;
    logic [31:0] rpm;
    logic [31:0] step;
    pick = $urandom_range(99);
    if (pick < 30) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        rpm = $urandom_range(32'(active.rpm_max) + 500);
        if ($urandom_range(1)) rpm = -rpm;
      end else if (pick < 55) begin
        rpm = 32'(active.rpm_min) + $urandom_range(4) - 2;
        if ($urandom_range(1)) rpm = -rpm;
      end else if (pick < 70) begin
        step = 32'(active.change_threshold) + $urandom_range(2) - 1;
        rpm  = $urandom_range(1) ? last_rpm + step : last_rpm - step;
      end else if (pick < 80) begin
        case ($urandom_range(3))
          0: rpm = 32'h8000_0000;
          1: rpm = 32'h7FFF_FFFF;
          2: rpm = 32'h0000_0000;
          default: rpm = 32'hFFFF_FFFF;
        endcase
      end else begin
        rpm = $urandom;
      end
      last_rpm = rpm;
      return speed_beat(rpm);
    end
    pick = $urandom_range(99);
    if (pick < 60) step = $urandom_range(50);
    else if (pick < 90) step = active.resend_interval_ms + $urandom_range(4) - 2;
    else step = $urandom;
    clock_ms = clock_ms + step;
    return tick_beat(clock_ms, $urandom_range(99) < 15, $urandom_range(99) < 75);
  endfunction

  // Leaves in_valid high on return; the caller either offers the next beat
  // or lowers it in the same time step.
  task automatic push_beat(input in_item_t beat);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(CFG_RPM_MIN, 32'(s.rpm_min));
    write_reg(CFG_RPM_MAX, 32'(s.rpm_max));
    write_reg(CFG_CHANGE_THR, 32'(s.change_threshold));
    write_reg(CFG_RESEND_MS, s.resend_interval_ms);
    write_reg(CFG_BROADCAST, 32'(s.broadcast_writes));
    write_reg(CFG_SLAVE_ADDR, 32'(s.slave_address));
    write_reg(CFG_INVERT_DIR, 32'(s.invert_direction));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Runs against the reset settings: 80 to 3000 rpm, threshold 5, resend 200 ms.
  task automatic run_directed();
    push_beat(tick_beat(32'd0, 1'b0, 1'b1));
    push_beat(speed_beat(32'h7FFF_FFFF));
    push_beat(tick_beat(32'd5, 1'b1, 1'b1));
    push_beat(tick_beat(32'd6, 1'b0, 1'b0));
    push_beat(tick_beat(32'd7, 1'b0, 1'b1));
    // The most negative request lands while the command write is still due.
    push_beat(speed_beat(32'h8000_0000));
    push_beat(tick_beat(32'd8, 1'b0, 1'b1));
    push_beat(speed_beat(32'd79));
    push_beat(tick_beat(32'd9, 1'b0, 1'b1));
    push_beat(tick_beat(32'd10, 1'b0, 1'b0));
    push_beat(tick_beat(32'd11, 1'b0, 1'b1));
    push_beat(speed_beat(32'd80));
    push_beat(tick_beat(32'd12, 1'b0, 1'b1));
    push_beat(tick_beat(32'd13, 1'b0, 1'b1));
    push_beat(speed_beat(32'd85));
    push_beat(tick_beat(32'd14, 1'b0, 1'b1));
    push_beat(speed_beat(32'd86));
    push_beat(tick_beat(32'd15, 1'b0, 1'b1));
    push_beat(tick_beat(32'd214, 1'b0, 1'b1));
    push_beat(tick_beat(32'd414, 1'b0, 1'b1));
    push_beat(speed_beat(32'hFFFF_FFFF));
    push_beat(tick_beat(32'd415, 1'b0, 1'b1));
    push_beat(tick_beat(32'd416, 1'b0, 1'b1));
    push_beat(speed_beat(-32'sd3001));
    push_beat(tick_beat(32'hFFFF_FF00, 1'b0, 1'b1));
    push_beat(tick_beat(32'hFFFF_FF01, 1'b0, 1'b1));
    // The keep-alive age is taken across the wrap of the millisecond counter.
    push_beat(tick_beat(32'h0000_0010, 1'b0, 1'b1));
    push_beat(speed_beat(32'd0));
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    clock_ms  = 32'd0;
    last_rpm  = 32'd0;
    active    = phase_settings(0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    settle_results();
    clock_ms = 32'h10;
    for (int p = 0; p < SETTING_COUNT; p++) begin
      active = phase_settings(p);
      load_settings(active);
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 77;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 77;
        end
        default: begin
          sender_idle_pct    = 30;
          receiver_stall_pct = 30;
        end
      endcase
      if (p % 2) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
      repeat (BEATS_PER_SETTING) begin
        push_beat(random_beat());
        if ($urandom_range(99) == 0) settle_results();
      end
      settle_results();
    end
    @(negedge clk);
    $display("Sent %0d beats across %0d register settings and four pacing modes.",
             beats_sent, settings_loaded + 1);
    $display("The block issued %0d speed writes and %0d command writes.",
             speed_writes, command_writes);
    if (mismatch_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mcs_pkg.sv
sv/mcs_shaper.sv
sv/mcs_sched.sv
sv/motor_command_scheduler_core.sv
verif/mcs_write_checker.sv
verif/tb_motor_command_scheduler_core.sv
